>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands used by the checker file trov_checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// what must hold on the cycle after reset is seen low
`define ASSERT_RESET_NEXT(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) !(rst_n) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/trov_pkg.sv
// ----------------------------------------------------------------------------
// trov_pkg
// types, widths and helpers for the triangle / rectangle overlap pipeline
// ----------------------------------------------------------------------------
package trov_pkg;

    localparam int CW               = 16;  // coordinate width, signed 8.8
    localparam int DW               = CW + 1;  // exact coordinate difference
    localparam int PW               = 2 * DW;  // exact product
    localparam int OW               = PW + 1;  // exact difference of products
    localparam int NUM_VERT         = 3;
    localparam int NUM_CORNER       = 4;
    localparam int NUM_EDGE_ORIENT  = NUM_VERT * NUM_CORNER;
    localparam int NUM_ORIENT       = 2 * NUM_EDGE_ORIENT;
    localparam int IN_BITS          = 10 * CW;
    localparam int OUT_BITS         = 8;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [DW-1:0] t_delta;
    typedef logic signed [PW-1:0] t_wide;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    // orientation of (a, b, c) is ux * vy - uy * vx with u = b - a, v = c - a
    typedef struct packed {
        t_delta ux;
        t_delta uy;
        t_delta vx;
        t_delta vy;
    } t_diff;

    typedef struct packed {
        t_wide p;
        t_wide q;
    } t_prod;

    typedef struct packed {
        logic neg;
        logic pos;
    } t_sgn;

    function automatic t_delta coord_sub(t_coord a, t_coord b);
        return {a[CW-1], a} - {b[CW-1], b};
    endfunction

    function automatic t_diff orient_diff(t_point a, t_point b, t_point c);
        t_diff d;
        d.ux = coord_sub(b.x, a.x);
        d.uy = coord_sub(b.y, a.y);
        d.vx = coord_sub(c.x, a.x);
        d.vy = coord_sub(c.y, a.y);
        return d;
    endfunction

    function automatic logic opposite(t_sgn a, t_sgn b);
        return (a.neg && b.pos) || (a.pos && b.neg);
    endfunction

endpackage

>>> rtl/core/triangle_rectangle_overlap_test_top.sv
// ----------------------------------------------------------------------------
// triangle_rectangle_overlap_test_top
// 2d triangle against axis-aligned rectangle overlap flag, four-stage pipeline
// ----------------------------------------------------------------------------
// channel   direction  tdata bits  contents
// s_axis    in         160         rectangle bounds and three vertices
// m_axis    out        8           overlap flag in bit 0
//
// one transaction per cycle sustained while m_axis_tready is high; a result
// passes the difference, multiply, sign and decide stages in that order
// reset clears only the stage valid bits
// a stalled output holds every full stage; an empty stage still fills, so
// bubbles are squeezed out and nothing is lost or repeated
// ----------------------------------------------------------------------------
module triangle_rectangle_overlap_test_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // rect_min_x, rect_min_y, rect_max_x, rect_max_y, v0_x, v0_y, v1_x, v1_y,
    // v2_x, v2_y, 16 bits each from bit 0 up
    input  logic [trov_pkg::IN_BITS-1:0]     s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // overlaps in bit 0, zero padded
    output logic [trov_pkg::OUT_BITS-1:0]    m_axis_tdata
);
    import trov_pkg::*;

    localparam int NUM_STAGE = 4;

    logic [NUM_STAGE-1:0]    r_valid;
    logic [NUM_STAGE-1:0]    adv;
    t_point                  lo;
    t_point                  hi;
    t_point [NUM_VERT-1:0]   vert;
    t_diff  [NUM_ORIENT-1:0] diff;
    t_prod  [NUM_ORIENT-1:0] prod;
    t_sgn   [NUM_ORIENT-1:0] sgn;
    logic                    hit_d;
    logic                    r_hit_p;
    logic                    r_hit_s;
    logic                    flag;

    // a stage takes new data when it is empty or its contents move on
    always_comb begin
        adv[NUM_STAGE-1] = !r_valid[NUM_STAGE-1] || m_axis_tready;
        for (int s = NUM_STAGE-2; s >= 0; s--) begin
            adv[s] = !r_valid[s] || adv[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (adv[0]) begin
                r_valid[0] <= s_axis_tvalid;
            end
            for (int s = 1; s < NUM_STAGE; s++) begin
                if (adv[s]) begin
                    r_valid[s] <= r_valid[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_hit_p <= hit_d;
        end
        if (adv[2]) begin
            r_hit_s <= r_hit_p;
        end
    end

    always_comb begin
        lo.x = s_axis_tdata[0*CW +: CW];
        lo.y = s_axis_tdata[1*CW +: CW];
        hi.x = s_axis_tdata[2*CW +: CW];
        hi.y = s_axis_tdata[3*CW +: CW];
        for (int i = 0; i < NUM_VERT; i++) begin
            vert[i].x = s_axis_tdata[(4+2*i)*CW +: CW];
            vert[i].y = s_axis_tdata[(5+2*i)*CW +: CW];
        end
    end

    trov_diff u_diff (
        .i_clk  (i_clk),
        .i_en   (adv[0]),
        .i_lo   (lo),
        .i_hi   (hi),
        .i_vert (vert),
        .o_diff (diff),
        .o_hit  (hit_d)
    );

    trov_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (adv[1]),
        .i_diff (diff),
        .o_prod (prod)
    );

    trov_sign u_sign (
        .i_clk  (i_clk),
        .i_en   (adv[2]),
        .i_prod (prod),
        .o_sgn  (sgn)
    );

    trov_decide u_decide (
        .i_clk  (i_clk),
        .i_en   (adv[3]),
        .i_sgn  (sgn),
        .i_hit  (r_hit_s),
        .o_flag (flag)
    );

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = r_valid[NUM_STAGE-1];
    assign m_axis_tdata  = {{(OUT_BITS-1){1'b0}}, flag};

endmodule

>>> rtl/core/trov_diff.sv
// ----------------------------------------------------------------------------
// trov_diff
// first stage: corner forming, coordinate differences, vertex-in-box test
// ----------------------------------------------------------------------------
module trov_diff (
    input  logic                                        i_clk,
    input  logic                                        i_en,
    input  trov_pkg::t_point                            i_lo,
    input  trov_pkg::t_point                            i_hi,
    input  trov_pkg::t_point [trov_pkg::NUM_VERT-1:0]   i_vert,
    output trov_pkg::t_diff  [trov_pkg::NUM_ORIENT-1:0] o_diff,
    output logic                                        o_hit
);
    import trov_pkg::*;

    t_point [NUM_CORNER-1:0] corner;
    t_diff  [NUM_ORIENT-1:0] n_diff;
    t_diff  [NUM_ORIENT-1:0] r_diff;
    logic                    n_hit;
    logic                    r_hit;

    // corners A, B, C, D from the bounds as given
    always_comb begin
        corner[0].x = i_lo.x;
        corner[0].y = i_lo.y;
        corner[1].x = i_hi.x;
        corner[1].y = i_lo.y;
        corner[2].x = i_lo.x;
        corner[2].y = i_hi.y;
        corner[3].x = i_hi.x;
        corner[3].y = i_hi.y;
    end

    always_comb begin
        n_hit = 1'b0;
        // triangle edge against each corner
        for (int i = 0; i < NUM_VERT; i++) begin
            for (int k = 0; k < NUM_CORNER; k++) begin
                n_diff[i*NUM_CORNER+k] = orient_diff(i_vert[i],
                    i_vert[(i == NUM_VERT-1) ? 0 : i+1], corner[k]);
            end
        end
        // corner-pair segment against each vertex
        for (int k = 0; k < NUM_CORNER; k++) begin
            for (int j = 0; j < NUM_VERT; j++) begin
                n_diff[NUM_EDGE_ORIENT+k*NUM_VERT+j] = orient_diff(corner[k],
                    corner[(k == NUM_CORNER-1) ? 0 : k+1], i_vert[j]);
            end
        end
        for (int i = 0; i < NUM_VERT; i++) begin
            if ($signed(i_vert[i].x) >= $signed(i_lo.x) &&
                $signed(i_vert[i].x) <= $signed(i_hi.x) &&
                $signed(i_vert[i].y) >= $signed(i_lo.y) &&
                $signed(i_vert[i].y) <= $signed(i_hi.y)) begin
                n_hit = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff <= n_diff;
            r_hit  <= n_hit;
        end
    end

    assign o_diff = r_diff;
    assign o_hit  = r_hit;

endmodule

>>> rtl/core/trov_mul.sv
// ----------------------------------------------------------------------------
// trov_mul
// second stage: the two exact products of every orientation
// ----------------------------------------------------------------------------
module trov_mul (
    input  logic                                        i_clk,
    input  logic                                        i_en,
    input  trov_pkg::t_diff  [trov_pkg::NUM_ORIENT-1:0] i_diff,
    output trov_pkg::t_prod  [trov_pkg::NUM_ORIENT-1:0] o_prod
);
    import trov_pkg::*;

    t_prod [NUM_ORIENT-1:0] n_prod;
    t_prod [NUM_ORIENT-1:0] r_prod;

    always_comb begin
        for (int n = 0; n < NUM_ORIENT; n++) begin
            n_prod[n].p = i_diff[n].ux * i_diff[n].vy;
            n_prod[n].q = i_diff[n].uy * i_diff[n].vx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

>>> rtl/core/trov_sign.sv
// ----------------------------------------------------------------------------
// trov_sign
// third stage: exact orientation value reduced to negative / positive flags
// ----------------------------------------------------------------------------
module trov_sign (
    input  logic                                        i_clk,
    input  logic                                        i_en,
    input  trov_pkg::t_prod  [trov_pkg::NUM_ORIENT-1:0] i_prod,
    output trov_pkg::t_sgn   [trov_pkg::NUM_ORIENT-1:0] o_sgn
);
    import trov_pkg::*;

    logic signed [OW-1:0] full [NUM_ORIENT];
    t_sgn [NUM_ORIENT-1:0] n_sgn;
    t_sgn [NUM_ORIENT-1:0] r_sgn;

    always_comb begin
        for (int n = 0; n < NUM_ORIENT; n++) begin
            full[n]      = i_prod[n].p - i_prod[n].q;
            n_sgn[n].neg = full[n][OW-1];
            n_sgn[n].pos = !full[n][OW-1] && (full[n] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sgn <= n_sgn;
        end
    end

    assign o_sgn = r_sgn;

endmodule

>>> rtl/core/trov_decide.sv
// ----------------------------------------------------------------------------
// trov_decide
// last stage: vertex-in-box hit, corner-in-triangle and strict crossing tests, output register
// ----------------------------------------------------------------------------
module trov_decide (
    input  logic                                        i_clk,
    input  logic                                        i_en,
    input  trov_pkg::t_sgn   [trov_pkg::NUM_ORIENT-1:0] i_sgn,
    input  logic                                        i_hit,
    output logic                                        o_flag
);
    import trov_pkg::*;

    logic n_flag;
    logic r_flag;

    always_comb begin
        n_flag = i_hit;
        // corner inside when its orientations against all triangle edges share one negative flag
        for (int k = 0; k < NUM_CORNER; k++) begin
            if ((i_sgn[k].neg == i_sgn[NUM_CORNER+k].neg) &&
                (i_sgn[NUM_CORNER+k].neg == i_sgn[2*NUM_CORNER+k].neg)) begin
                n_flag = 1'b1;
            end
        end
        // edge i against segment from corner k to the next corner
        for (int i = 0; i < NUM_VERT; i++) begin
            for (int k = 0; k < NUM_CORNER; k++) begin
                if (opposite(i_sgn[i*NUM_CORNER+k],
                        i_sgn[i*NUM_CORNER+((k == NUM_CORNER-1) ? 0 : k+1)]) &&
                    opposite(i_sgn[NUM_EDGE_ORIENT+k*NUM_VERT+i],
                        i_sgn[NUM_EDGE_ORIENT+k*NUM_VERT+
                              ((i == NUM_VERT-1) ? 0 : i+1)])) begin
                    n_flag = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flag <= n_flag;
        end
    end

    assign o_flag = r_flag;

endmodule

>>> rtl/core/trov_checker.sv
// ----------------------------------------------------------------------------
// trov_checker
// port-level checks on the overlap pipeline, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trov_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tready,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [trov_pkg::OUT_BITS-1:0]    m_axis_tdata
);
    import trov_pkg::*;

    // a waiting result keeps its value
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // only the flag bit may be set
    `ASSERT_IMPLIES(a_pad_zero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[OUT_BITS-1:1] == '0)

    // input back-pressure only comes from a full pipe behind a stalled output
    `ASSERT_IMPLIES(a_full_stall, i_clk, i_rst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

    // reset empties the pipe
    `ASSERT_RESET_NEXT(a_reset_empty, i_clk, i_rst_n, !m_axis_tvalid && s_axis_tready)

endmodule

bind triangle_rectangle_overlap_test_top trov_checker u_checker (.*);
